// ----- sv/tcal_pkg.sv -----
// Package for the tree common ancestor lifting block.
// Holds default sizes, status codes, register index and the config struct.
// No dependencies.
package tcal_pkg;

  localparam int MAX_NODES_DEF   = 65536;
  localparam int LIFT_LEVELS_DEF = 16;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_NOT_BUILT = 2'd2;

  localparam logic REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic [16:0] node_count;
    logic        wr;
  } tcal_cfg_t;

endpackage

// ----- sv/tree_common_ancestor_lifting.sv -----
// Top level: lowest common ancestor by binary lifting, with sequencer.
// Depends on tcal_pkg, tcal_ram, tcal_cfg.
//
//  channel  | handshake          | payload
//  input    | start / busy       | in_kind, in_node_a, in_node_b, in_last_entry
//  result   | out_valid strobe   | out_ancestor, out_status
//  config   | psel/penable/pready| paddr, pwdata, prdata
//
// A load entry is written when it is accepted. A build is paced by the one read port
// of the ancestor RAM. A query holds busy through its depth, lift and ancestor
// compare steps, or through depth and lift only when one node lifts onto the other; its
// result strobes in the cycle after. A rejected query answers next cycle without busy.
// Reset is synchronous; the RAMs are not cleared. The receiver cannot stall.
module tree_common_ancestor_lifting #(
  parameter int MAX_NODES   = tcal_pkg::MAX_NODES_DEF,
  parameter int LIFT_LEVELS = tcal_pkg::LIFT_LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [15:0] in_node_a,
  input  logic [15:0] in_node_b,
  input  logic        in_last_entry,
  output logic        out_valid,
  output logic [15:0] out_ancestor,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcal_pkg::*;

  localparam int NW     = $clog2(MAX_NODES);
  localparam int CW     = ($clog2(MAX_NODES + 1) > 17) ? $clog2(MAX_NODES + 1) : 17;
  localparam int LW     = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int ADEPTH = LIFT_LEVELS * (2 ** NW);
  localparam int RAW    = $clog2(ADEPTH);
  localparam int DSW    = (LIFT_LEVELS + 2 > 17) ? LIFT_LEVELS + 2 : 17;

  typedef enum logic [18:0] {
    S_IDLE      = 19'b0000000000000000001,
    S_FIX_RD    = 19'b0000000000000000010,
    S_FIX_WR    = 19'b0000000000000000100,
    S_LIFT_RD1  = 19'b0000000000000001000,
    S_LIFT_RD2  = 19'b0000000000000010000,
    S_LIFT_WR   = 19'b0000000000000100000,
    S_DEP_INIT  = 19'b0000000000001000000,
    S_DEP_RD    = 19'b0000000000010000000,
    S_DEP_USE   = 19'b0000000000100000000,
    S_DEP_WR    = 19'b0000000001000000000,
    S_Q_DA      = 19'b0000000010000000000,
    S_Q_DB      = 19'b0000000100000000000,
    S_Q_SWAP    = 19'b0000001000000000000,
    S_Q_UP_RD   = 19'b0000010000000000000,
    S_Q_UP_USE  = 19'b0000100000000000000,
    S_Q_LA      = 19'b0001000000000000000,
    S_Q_LB      = 19'b0010000000000000000,
    S_Q_LCMP    = 19'b0100000000000000000,
    S_Q_FIN     = 19'b1000000000000000000
  } state_t;

  tcal_cfg_t cfg;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [LW-1:0]      k_r, k_nxt;
  logic [NW-1:0]      x_r, x_nxt;
  logic [NW-1:0]      a_r, a_nxt;
  logic [NW-1:0]      b_r, b_nxt;
  logic [NW-1:0]      pa_r, pa_nxt;
  logic [DSW-1:0]     d_r, d_nxt;
  logic [15:0]        da_r, da_nxt;
  logic [LIFT_LEVELS-1:0] diff_r, diff_nxt;
  logic               built_r, built_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_anc_r, out_anc_nxt;
  logic [1:0]         out_stat_r, out_stat_nxt;

  logic [CW-1:0]      n_eff;
  logic               acc;
  logic [15:0]        dif16_w;
  logic [DSW-1:0]     dsum_w;

  logic               anc_we;
  logic [LW+NW-1:0]   anc_waddr, anc_raddr;
  logic [NW-1:0]      anc_wdata, anc_rdata;
  logic               dep_we;
  logic [NW-1:0]      dep_waddr, dep_raddr;
  logic [15:0]        dep_wdata, dep_rdata;

  tcal_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcal_ram #(.WIDTH(NW), .DEPTH(ADEPTH)) u_anc_ram (
    .clk   (clk),
    .we    (anc_we),
    .waddr (RAW'(anc_waddr)),
    .wdata (anc_wdata),
    .raddr (RAW'(anc_raddr)),
    .rdata (anc_rdata)
  );

  tcal_ram #(.WIDTH(16), .DEPTH(2 ** NW)) u_dep_ram (
    .clk   (clk),
    .we    (dep_we),
    .waddr (dep_waddr),
    .wdata (dep_wdata),
    .raddr (dep_raddr),
    .rdata (dep_rdata)
  );

  assign n_eff = (CW'(cfg.node_count) < CW'(MAX_NODES)) ? CW'(cfg.node_count)
                                                       : CW'(MAX_NODES);
  assign busy  = (state_r != S_IDLE);
  assign acc   = start && !busy;
  assign dif16_w = (da_r < dep_rdata) ? (dep_rdata - da_r) : (da_r - dep_rdata);
  assign dsum_w  = d_r + DSW'(x_r != '0);

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    x_nxt         = x_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    pa_nxt        = pa_r;
    d_nxt         = d_r;
    da_nxt        = da_r;
    diff_nxt      = diff_r;
    built_nxt     = built_r;
    out_valid_nxt = 1'b0;
    out_anc_nxt   = out_anc_r;
    out_stat_nxt  = out_stat_r;
    anc_we        = 1'b0;
    anc_waddr     = {LW'(0), i_r[NW-1:0]};
    anc_wdata     = '0;
    anc_raddr     = {LW'(0), i_r[NW-1:0]};
    dep_we        = 1'b0;
    dep_waddr     = i_r[NW-1:0];
    dep_wdata     = (dsum_w > DSW'(16'hFFFF)) ? 16'hFFFF : dsum_w[15:0];
    dep_raddr     = a_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (!in_kind) begin
            built_nxt = 1'b0;
            if (in_node_a != 16'd0 && CW'(in_node_a) < n_eff && CW'(in_node_b) < n_eff) begin
              anc_we    = 1'b1;
              anc_waddr = {LW'(0), NW'(in_node_a)};
              anc_wdata = NW'(in_node_b);
            end
            if (in_last_entry) begin
              if (n_eff == '0) begin
                built_nxt = 1'b1;
              end else begin
                i_nxt     = '0;
                state_nxt = S_FIX_RD;
              end
            end
          end else if (!built_r) begin
            out_valid_nxt = 1'b1;
            out_anc_nxt   = 16'd0;
            out_stat_nxt  = STATUS_NOT_BUILT;
          end else if (CW'(in_node_a) >= n_eff || CW'(in_node_b) >= n_eff) begin
            out_valid_nxt = 1'b1;
            out_anc_nxt   = 16'd0;
            out_stat_nxt  = STATUS_RANGE;
          end else begin
            a_nxt     = NW'(in_node_a);
            b_nxt     = NW'(in_node_b);
            state_nxt = S_Q_DA;
          end
        end
      end
      S_FIX_RD: begin
        state_nxt = S_FIX_WR;
      end
      S_FIX_WR: begin
        if (CW'(anc_rdata) >= n_eff || i_r == '0) begin
          anc_we = 1'b1;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_FIX_RD;
        if (i_r + 1'b1 == n_eff) begin
          i_nxt = '0;
          if (LIFT_LEVELS == 1) begin
            state_nxt = S_DEP_INIT;
          end else begin
            k_nxt     = LW'(1);
            state_nxt = S_LIFT_RD1;
          end
        end
      end
      S_LIFT_RD1: begin
        anc_raddr = {LW'(k_r - 1'b1), i_r[NW-1:0]};
        state_nxt = S_LIFT_RD2;
      end
      S_LIFT_RD2: begin
        anc_raddr = {LW'(k_r - 1'b1), anc_rdata};
        state_nxt = S_LIFT_WR;
      end
      S_LIFT_WR: begin
        anc_we    = 1'b1;
        anc_waddr = {k_r, i_r[NW-1:0]};
        anc_wdata = anc_rdata;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_LIFT_RD1;
        if (i_r + 1'b1 == n_eff) begin
          i_nxt = '0;
          if (k_r == LW'(LIFT_LEVELS - 1)) begin
            state_nxt = S_DEP_INIT;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      S_DEP_INIT: begin
        x_nxt     = i_r[NW-1:0];
        d_nxt     = '0;
        k_nxt     = LW'(LIFT_LEVELS - 1);
        state_nxt = S_DEP_RD;
      end
      S_DEP_RD: begin
        anc_raddr = {k_r, x_r};
        state_nxt = S_DEP_USE;
      end
      S_DEP_USE: begin
        if (anc_rdata != '0) begin
          d_nxt = d_r + (DSW'(1) << k_r);
          x_nxt = anc_rdata;
        end
        if (k_r == '0) begin
          state_nxt = S_DEP_WR;
        end else begin
          k_nxt     = k_r - 1'b1;
          state_nxt = S_DEP_RD;
        end
      end
      S_DEP_WR: begin
        dep_we    = 1'b1;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_DEP_INIT;
        if (i_r + 1'b1 == n_eff) begin
          built_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_Q_DA: begin
        dep_raddr = a_r;
        state_nxt = S_Q_DB;
      end
      S_Q_DB: begin
        dep_raddr = b_r;
        da_nxt    = dep_rdata;
        state_nxt = S_Q_SWAP;
      end
      S_Q_SWAP: begin
        if (da_r < dep_rdata) begin
          a_nxt = b_r;
          b_nxt = a_r;
        end
        diff_nxt  = LIFT_LEVELS'(dif16_w);
        k_nxt     = '0;
        state_nxt = S_Q_UP_RD;
      end
      S_Q_UP_RD: begin
        anc_raddr = {k_r, a_r};
        state_nxt = S_Q_UP_USE;
      end
      S_Q_UP_USE: begin
        if (diff_r[k_r]) begin
          a_nxt = anc_rdata;
        end
        if (k_r == LW'(LIFT_LEVELS - 1)) begin
          k_nxt = LW'(LIFT_LEVELS - 1);
          if ((diff_r[k_r] ? anc_rdata : a_r) == b_r) begin
            out_valid_nxt = 1'b1;
            out_anc_nxt   = 16'(b_r);
            out_stat_nxt  = STATUS_OK;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_Q_LA;
          end
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_Q_UP_RD;
        end
      end
      S_Q_LA: begin
        anc_raddr = {k_r, a_r};
        state_nxt = S_Q_LB;
      end
      S_Q_LB: begin
        anc_raddr = {k_r, b_r};
        pa_nxt    = anc_rdata;
        state_nxt = S_Q_LCMP;
      end
      S_Q_LCMP: begin
        if (pa_r != anc_rdata) begin
          a_nxt = pa_r;
          b_nxt = anc_rdata;
        end
        if (k_r == '0) begin
          state_nxt = S_Q_FIN;
        end else begin
          k_nxt     = k_r - 1'b1;
          state_nxt = S_Q_LA;
        end
      end
      S_Q_FIN: begin
        anc_raddr = {LW'(0), a_r};
        x_nxt     = a_r;
        state_nxt = S_IDLE;
        out_stat_nxt = STATUS_OK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg.wr) begin
      built_nxt = 1'b0;
    end
  end

  // result of the final parent read lands in the cycle after the last query step
  logic fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt || (state_r == S_Q_FIN);
      fin_r       <= (state_r == S_Q_FIN);
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    x_r        <= x_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    pa_r       <= pa_nxt;
    d_r        <= d_nxt;
    da_r       <= da_nxt;
    diff_r     <= diff_nxt;
    out_anc_r  <= out_anc_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_ancestor = fin_r ? 16'(anc_rdata) : out_anc_r;
  assign out_status   = out_stat_r;

`ifndef SYNTH
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");
  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_kind && !(in_last_entry && n_eff == '0)) |=> !built_r)
    else $error("load did not clear build flag");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("bad status code");
  a_built_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(built_r) |-> ($past(state_r) == S_DEP_WR || $past(state_r) == S_IDLE))
    else $error("build flag set outside build end");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (out_valid && out_status == STATUS_OK))
    else $error("final read without ok result");
`endif

endmodule

// ----- sv/tcal_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcal_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/tcal_cfg.sv -----
// APB-style register port holding node_count.
// Depends on tcal_pkg.
module tcal_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output tcal_pkg::tcal_cfg_t cfg
);
  import tcal_pkg::*;

  logic [16:0] node_count_r;
  logic        wr_w;

  assign wr_w   = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 17'd1;
    end else if (wr_w) begin
      node_count_r <= pwdata[16:0];
    end
  end

  assign cfg.node_count = node_count_r;
  assign cfg.wr         = wr_w;

endmodule
